### design/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared constants, register indexes, controller states and the command and
// status bundles between the seek scheduler controller and datapath.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int MAX_REQUESTS  = 64;
    localparam int TRACK_BITS    = 16;
    localparam int TOTAL_BITS    = 22;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_MODE       = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_START_HEAD = 1'd1;

    // service order codes
    localparam logic MODE_FCFS = 1'b0;
    localparam logic MODE_LOOK = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_FETCH,
        ST_CAPTURE,
        ST_SCAN,
        ST_FLUSH,
        ST_PICK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic scan_issue;
        logic capture;
        logic pass_switch;
        logic emit;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic fcfs;
        logic found;
        logic scan_last;
        logic out_free;
        logic last_res;
        logic pass_down;
    } t_dp_stat;

endpackage

### design/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/dss_ctrl.sv
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer of the seek scheduler: load phase, then one fetch (FCFS) or one
// full store scan (LOOK) per served request, then the result hand-off.
// ----------------------------------------------------------------------------
module dss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  dss_pkg::t_dp_stat i_stat,
    output dss_pkg::t_dp_cmd  o_cmd,
    output logic             o_in_ready
);

    dss_pkg::t_state r_state;
    dss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dss_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dss_pkg::ST_LOAD: begin
                if (i_in_valid && i_in_last) begin
                    n_state = dss_pkg::ST_SETUP;
                end
            end
            dss_pkg::ST_SETUP: begin
                n_state = i_stat.fcfs ? dss_pkg::ST_FETCH : dss_pkg::ST_SCAN;
            end
            dss_pkg::ST_FETCH: begin
                n_state = dss_pkg::ST_CAPTURE;
            end
            dss_pkg::ST_CAPTURE: begin
                n_state = dss_pkg::ST_EMIT;
            end
            dss_pkg::ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = dss_pkg::ST_FLUSH;
                end
            end
            dss_pkg::ST_FLUSH: begin
                n_state = dss_pkg::ST_PICK;
            end
            dss_pkg::ST_PICK: begin
                priority if (i_stat.found) begin
                    n_state = dss_pkg::ST_EMIT;
                end else if (!i_stat.pass_down) begin
                    n_state = dss_pkg::ST_SCAN;
                end else begin
                    n_state = dss_pkg::ST_LOAD;
                end
            end
            dss_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    priority if (i_stat.last_res) begin
                        n_state = dss_pkg::ST_LOAD;
                    end else if (i_stat.fcfs) begin
                        n_state = dss_pkg::ST_FETCH;
                    end else begin
                        n_state = dss_pkg::ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = dss_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            dss_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            dss_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            dss_pkg::ST_FETCH: begin
                o_cmd = '0;
            end
            dss_pkg::ST_CAPTURE: begin
                o_cmd.capture = 1'b1;
            end
            dss_pkg::ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
            end
            dss_pkg::ST_FLUSH: begin
                o_cmd = '0;
            end
            dss_pkg::ST_PICK: begin
                // empty upward pass: turn around; empty downward pass: close batch
                o_cmd.pass_switch = !i_stat.found && !i_stat.pass_down;
                o_cmd.finish      = !i_stat.found && i_stat.pass_down;
            end
            dss_pkg::ST_EMIT: begin
                o_cmd.emit   = i_stat.out_free;
                o_cmd.finish = i_stat.out_free && i_stat.last_res;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### design/dss_dp.sv
// ----------------------------------------------------------------------------
// dss_dp
// Datapath of the seek scheduler: request store, configuration registers,
// scan compare against the last served request, seek arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module dss_dp #(
    parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS,
    parameter int TRACK_BITS   = dss_pkg::TRACK_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dss_pkg::t_dp_cmd                  i_cmd,
    output dss_pkg::t_dp_stat                 o_stat,
    input  logic [TRACK_BITS-1:0]             i_track,
    input  logic                              i_cfg_valid,
    input  logic [dss_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [dss_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [TRACK_BITS-1:0]             o_served_track,
    output logic [TRACK_BITS-1:0]             o_seek_distance,
    output logic [dss_pkg::TOTAL_BITS-1:0]    o_total_seek,
    output logic                              o_last_served,
    output logic                              o_dropped
);

    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int TOT_W = dss_pkg::TOTAL_BITS;
    localparam int CFG_W = dss_pkg::CFG_DATA_BITS;

    // configuration
    logic                  r_mode;
    logic [TRACK_BITS-1:0] r_start_head;
    logic [CFG_W+TRACK_BITS-1:0] cfg_ext;

    // batch state
    logic [CNT_W-1:0]      r_count;
    logic                  r_overflow;
    logic                  r_fcfs;
    logic [TRACK_BITS-1:0] r_base;
    logic [TRACK_BITS-1:0] r_head;
    logic [TOT_W-1:0]      r_sum;
    logic [CNT_W-1:0]      r_k;
    logic                  r_pass_down;

    // scan state
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_cv;
    logic [IDX_W-1:0]      r_ci;
    logic                  r_found;
    logic [TRACK_BITS-1:0] r_best_trk;
    logic [IDX_W-1:0]      r_best_idx;
    logic                  r_prev_vld;
    logic [TRACK_BITS-1:0] r_prev_trk;
    logic [IDX_W-1:0]      r_prev_idx;

    // output register
    logic                  r_out_vld;
    logic [TRACK_BITS-1:0] r_out_trk;
    logic [TRACK_BITS-1:0] r_out_dist;
    logic [TOT_W-1:0]      r_out_total;
    logic                  r_out_last;
    logic                  r_out_drop;

    logic                  store_we;
    logic [IDX_W-1:0]      raddr;
    logic [TRACK_BITS-1:0] rd_trk;
    logic                  above;
    logic                  same_after;
    logic                  after_up;
    logic                  after_dn;
    logic                  elig;
    logic                  better;
    logic                  take;
    logic [TRACK_BITS-1:0] seek_dist;
    logic [TRACK_BITS+TOT_W-1:0] dist_ext;
    logic [TOT_W-1:0]      sum_new;
    logic                  last_res;
    logic                  out_free;

    assign cfg_ext  = {{TRACK_BITS{1'b0}}, i_cfg_data};
    assign store_we = i_cmd.load && (r_count < CNT_W'(MAX_REQUESTS));
    assign raddr    = r_fcfs ? r_k[IDX_W-1:0] : r_rd_idx;

    dss_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_track),
        .i_raddr (raddr),
        .o_rdata (rd_trk)
    );

    // LOOK selection: the next request is the nearest one past the last
    // served (track, index) key in the direction of the current pass;
    // equal tracks go out in arrival order.
    always_comb begin
        above      = rd_trk >= r_base;
        same_after = (rd_trk == r_prev_trk) && (r_ci > r_prev_idx);
        after_up   = !r_prev_vld || (rd_trk > r_prev_trk) || same_after;
        after_dn   = !r_prev_vld || (rd_trk < r_prev_trk) || same_after;
        elig       = r_pass_down ? (!above && after_dn) : (above && after_up);
        better     = !r_found || (r_pass_down ? (rd_trk > r_best_trk)
                                              : (rd_trk < r_best_trk));
        take       = r_cv && elig && better;
    end

    always_comb begin
        seek_dist = (r_best_trk >= r_head) ? (r_best_trk - r_head)
                                           : (r_head - r_best_trk);
        dist_ext  = {{TOT_W{1'b0}}, seek_dist};
        sum_new   = r_sum + dist_ext[TOT_W-1:0];
        last_res  = (r_k + CNT_W'(1)) == r_count;
        out_free  = !r_out_vld || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= dss_pkg::MODE_FCFS;
            r_start_head <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                dss_pkg::REG_MODE:       r_mode       <= i_cfg_data[0];
                dss_pkg::REG_START_HEAD: r_start_head <= cfg_ext[TRACK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // request count and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.finish) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.load) begin
            if (store_we) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_overflow <= 1'b1;
            end
        end
    end

    // batch progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcfs      <= 1'b1;
            r_base      <= '0;
            r_head      <= '0;
            r_sum       <= '0;
            r_k         <= '0;
            r_pass_down <= 1'b0;
            r_prev_vld  <= 1'b0;
            r_found     <= 1'b0;
            r_rd_idx    <= '0;
            r_cv        <= 1'b0;
        end else begin
            r_cv <= i_cmd.scan_issue;
            if (i_cmd.scan_issue) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.setup) begin
                r_fcfs      <= (r_mode == dss_pkg::MODE_FCFS);
                r_base      <= r_start_head;
                r_head      <= r_start_head;
                r_sum       <= '0;
                r_k         <= '0;
                r_pass_down <= 1'b0;
                r_prev_vld  <= 1'b0;
                r_found     <= 1'b0;
                r_rd_idx    <= '0;
            end
            if (i_cmd.pass_switch) begin
                r_pass_down <= 1'b1;
                r_prev_vld  <= 1'b0;
                r_found     <= 1'b0;
                r_rd_idx    <= '0;
            end
            if (i_cmd.emit) begin
                r_head     <= r_best_trk;
                r_sum      <= sum_new;
                r_k        <= r_k + CNT_W'(1);
                r_prev_vld <= 1'b1;
                r_found    <= 1'b0;
                r_rd_idx   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ci <= r_rd_idx;
        if (take) begin
            r_best_trk <= rd_trk;
            r_best_idx <= r_ci;
        end
        if (i_cmd.capture) begin
            r_best_trk <= rd_trk;
        end
        if (i_cmd.emit) begin
            r_prev_trk <= r_best_trk;
            r_prev_idx <= r_best_idx;
        end
    end

    // output register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_trk   <= r_best_trk;
            r_out_dist  <= seek_dist;
            r_out_total <= sum_new;
            r_out_last  <= last_res;
            r_out_drop  <= r_overflow;
        end
    end

    // during setup the order is decided from the mode register directly
    assign o_stat.fcfs      = i_cmd.setup ? (r_mode == dss_pkg::MODE_FCFS) : r_fcfs;
    assign o_stat.found     = r_found;
    assign o_stat.scan_last = (CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count;
    assign o_stat.out_free  = out_free;
    assign o_stat.last_res  = last_res;
    assign o_stat.pass_down = r_pass_down;

    assign o_out_valid     = r_out_vld;
    assign o_served_track  = r_out_trk;
    assign o_seek_distance = r_out_dist;
    assign o_total_seek    = r_out_total;
    assign o_last_served   = r_out_last;
    assign o_dropped       = r_out_drop;

endmodule

### design/disk_seek_scheduler.sv
// ----------------------------------------------------------------------------
// disk_seek_scheduler
// Batch disk-track scheduler with first-come-first-served and LOOK ordering.
// ----------------------------------------------------------------------------
// Usage:
//   Write mode (index 0) and start_head (index 1) on the cfg channel while
//   the block is idle. Send track requests on the s_axis channel, one beat
//   per cycle; tlast marks the final request of a batch. Requests beyond
//   MAX_REQUESTS are discarded and every result of that batch has tuser set.
//   After the tlast beat the input closes and the batch comes out on m_axis,
//   one beat per request, tlast on the final one.
//   Emission starts with a setup step. FCFS produces each result by a store
//   read, a capture and the hand-off. LOOK scans the whole store through its
//   single read port for every result, plus one extra scan when the upward
//   pass runs out.
//   Reset clears the control state, counters and configuration; the request
//   store keeps its contents and needs no clearing pass.
//   A stalled receiver holds the result in the output register and the
//   sequencer waits; the next batch may load while the final result waits.
// ----------------------------------------------------------------------------
module disk_seek_scheduler #(
    parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS,
    parameter int TRACK_BITS   = dss_pkg::TRACK_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dss_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [dss_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    // request stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((TRACK_BITS+7)/8)*8-1:0]       i_s_axis_tdata,  // track
    input  logic                                  i_s_axis_tlast,
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // served_track, seek_distance, total_seek
    output logic [((2*TRACK_BITS+dss_pkg::TOTAL_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    output logic                                  o_m_axis_tuser   // dropped
);

    localparam int OUT_W = ((2*TRACK_BITS+dss_pkg::TOTAL_BITS+7)/8)*8;

    dss_pkg::t_dp_cmd  cmd;
    dss_pkg::t_dp_stat stat;

    logic [TRACK_BITS-1:0]          served_track;
    logic [TRACK_BITS-1:0]          seek_distance;
    logic [dss_pkg::TOTAL_BITS-1:0] total_seek;

    dss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_s_axis_tready)
    );

    dss_dp #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_track         (i_s_axis_tdata[TRACK_BITS-1:0]),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_served_track  (served_track),
        .o_seek_distance (seek_distance),
        .o_total_seek    (total_seek),
        .o_last_served   (o_m_axis_tlast),
        .o_dropped       (o_m_axis_tuser)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = OUT_W'({total_seek, seek_distance, served_track});

endmodule

### design/dss_checker.sv
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks of the seek scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module dss_checker #(
    parameter int TRACK_BITS = dss_pkg::TRACK_BITS
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_axis_tvalid,
    input logic                                  o_s_axis_tready,
    input logic                                  i_s_axis_tlast,
    input logic                                  o_m_axis_tvalid,
    input logic                                  i_m_axis_tready,
    input logic [((2*TRACK_BITS+dss_pkg::TOTAL_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    input logic                                  o_m_axis_tlast,
    input logic                                  o_m_axis_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid &&
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) &&
            $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // reset leaves the block open for requests with no result pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("bad state after reset");

    // the input closes once the final request of a batch is taken
    a_close_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input still open after final request");

    // a new result comes only from the emission phase
    a_emit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result produced during load phase");

endmodule

bind disk_seek_scheduler dss_checker #(
    .TRACK_BITS (TRACK_BITS)
) u_dss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
